// File: src/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

  localparam int DEPTH = 128;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 8;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 56;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t entry;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/mpq_cell.sv
`default_nettype none

module mpq_cell (
  input  wire logic           clk,
  input  wire mpq_pkg::cmd_t  cmd,
  input  wire logic           occupied,
  input  wire logic           left_goes,
  input  wire mpq_pkg::entry_t left_entry,
  input  wire mpq_pkg::entry_t right_entry,
  output mpq_pkg::entry_t     entry,
  output logic                goes
);

  mpq_pkg::entry_t entry_next;

  // new item lands before this one only on a strictly lower priority,
  // so equal priorities keep arrival order
  assign goes = !occupied || (cmd.entry.prio < entry.prio);

  always_comb begin
    entry_next = entry;
    if (cmd.ins && goes) begin
      entry_next = left_goes ? left_entry : cmd.entry;
    end else if (cmd.del) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// File: src/min_priority_queue_unit.sv
// an accepted request beat gives its result beat in the next cycle
// throughput: one request per cycle while result beats are taken; every cell compares and shifts at once
// the result register frees up the input as soon as the result beat is taken
// reset clears the entry count and the result valid; cell contents are not
// cleared, only cells below the count are ever used
`default_nettype none

module min_priority_queue_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [mpq_pkg::S_DATA_W-1:0]  s_tdata,  // value[31:0], priority_req[47:32]
  input  wire logic                          s_tuser,  // func
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [mpq_pkg::M_DATA_W-1:0]  m_tdata,  // out_value[31:0], out_priority[47:32],
                                                       // count[55:48]
  output logic      [1:0]                    m_tuser   // status
);

  localparam int DEPTH = mpq_pkg::DEPTH;
  localparam int CNT_W = mpq_pkg::CNT_W;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  mpq_pkg::status_t         status;
  mpq_pkg::status_t         status_next;
  mpq_pkg::entry_t          result;
  mpq_pkg::entry_t          result_next;
  logic [mpq_pkg::COUNT_W-1:0] count_out;

  logic                     accept;
  logic                     is_deq;
  logic                     full;
  logic                     empty;
  mpq_pkg::cmd_t            cmd;

  mpq_pkg::entry_t          cell_entry [DEPTH];
  logic [DEPTH-1:0]         cell_goes;
  logic [DEPTH-1:0]         occupied;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_deq   = (mpq_pkg::op_t'(s_tuser) == mpq_pkg::OP_DEQ);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    cmd.ins         = accept && !is_deq && !full;
    cmd.del         = accept && is_deq && !empty;
    cmd.entry.value = s_tdata[31:0];
    cmd.entry.prio  = s_tdata[47:32];
  end

  always_comb begin
    count_next  = count;
    status_next = mpq_pkg::ST_DONE;
    result_next = '0;
    if (is_deq) begin
      if (empty) begin
        status_next = mpq_pkg::ST_EMPTY;
      end else begin
        count_next  = count - 1'b1;
        result_next = cell_entry[0];
      end
    end else begin
      if (full) begin
        status_next = mpq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      result    <= result_next;
      count_out <= mpq_pkg::COUNT_W'(count_next);
    end
  end

  assign m_tdata = {count_out, result.prio, result.value};
  assign m_tuser = status;

  // sorted chain: lowest priority at cell 0, arrival order among equals
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mpq_pkg::entry_t left_entry;
    mpq_pkg::entry_t right_entry;
    logic            left_goes;

    assign occupied[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_goes  = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_goes  = cell_goes[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied[i]),
      .left_goes   (left_goes),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .goes        (cell_goes[i])
    );
  end

endmodule

`default_nettype wire

// File: src/mpq_checker.sv
`default_nettype none

module mpq_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic [mpq_pkg::S_DATA_W-1:0] s_tdata,
  input wire logic                         s_tuser,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [mpq_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [1:0]                   m_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // a refused enqueue only happens with the queue at its limit
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == mpq_pkg::ST_FULL) |->
      m_tdata[55:48] == mpq_pkg::COUNT_W'(mpq_pkg::DEPTH))
    else $error("full status with count below depth");

  // an empty dequeue returns zeros and no entries
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == mpq_pkg::ST_EMPTY) |-> m_tdata == '0)
    else $error("empty status with non-zero payload");

  // a request taken while the result register is free shows a beat next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request gave no result beat");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind min_priority_queue_unit mpq_checker u_mpq_checker (.*);

`default_nettype wire
